// ----- sv/bhms_pkg.sv -----
// shared types, constants and helpers for the button hold mode selector
`default_nettype none

package bhms_pkg;

    localparam int HOLD_COUNT_BITS_DEF = 16;
    localparam int THR_W               = 16;
    localparam int CFG_DATA_W          = 32;
    localparam int CFG_ADDR_W          = 3;

    localparam logic [THR_W-1:0] SHORT_HOLD_RESET = 16'd50;
    localparam logic [THR_W-1:0] LONG_HOLD_RESET  = 16'd1000;

    typedef enum logic [0:0] {
        CMD_TICK = 1'b0,
        CMD_LINK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_IDLE        = 3'd0,
        MODE_LINKED      = 3'd1,
        MODE_BLACK       = 3'd2,
        MODE_IDENTIFY    = 3'd3,
        MODE_DARK_ORANGE = 3'd4,
        MODE_ORANGE      = 3'd5,
        MODE_AMBIENT     = 3'd6,
        MODE_WHITE       = 3'd7
    } t_mode;

    typedef enum logic [0:0] {
        REG_SHORT_HOLD = 1'b0,
        REG_LONG_HOLD  = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [THR_W-1:0] short_hold;
        logic [THR_W-1:0] long_hold;
    } t_cfg;

    typedef struct packed {
        logic active;
        logic release_handled;
        logic long_fired;
    } t_hold_status;

    // display mode cycle on a short release
    function automatic t_mode next_mode(input t_mode m);
        t_mode r;
        unique case (m)
            MODE_IDENTIFY:    r = MODE_DARK_ORANGE;
            MODE_DARK_ORANGE: r = MODE_ORANGE;
            MODE_ORANGE:      r = MODE_AMBIENT;
            MODE_AMBIENT:     r = MODE_WHITE;
            default:          r = MODE_IDENTIFY;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/bhms_if.sv -----
// item and result channel interfaces
`default_nettype none

interface bhms_item_if;
    logic valid;
    logic ready;
    logic cmd;
    logic button_pressed;

    modport source (output valid, output cmd, output button_pressed, input ready);
    modport sink   (input valid, input cmd, input button_pressed, output ready);
endinterface

interface bhms_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic       mode_changed;

    modport source (output valid, output mode, output mode_changed, input ready);
    modport sink   (input valid, input mode, input mode_changed, output ready);
endinterface

`default_nettype wire

// ----- sv/bhms_cfg.sv -----
// apb register block for the hold thresholds
`default_nettype none

module bhms_cfg import bhms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic [THR_W-1:0] r_short_hold;
    logic [THR_W-1:0] r_long_hold;
    logic             wr_en;
    t_reg_idx         reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_hold <= SHORT_HOLD_RESET;
            r_long_hold  <= LONG_HOLD_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_SHORT_HOLD: r_short_hold <= pwdata[THR_W-1:0];
                REG_LONG_HOLD:  r_long_hold  <= pwdata[THR_W-1:0];
                default:        r_short_hold <= r_short_hold;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SHORT_HOLD: prdata = {{(CFG_DATA_W-THR_W){1'b0}}, r_short_hold};
            REG_LONG_HOLD:  prdata = {{(CFG_DATA_W-THR_W){1'b0}}, r_long_hold};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.short_hold = r_short_hold;
    assign o_cfg.long_hold  = r_long_hold;

endmodule

`default_nettype wire

// ----- sv/bhms_hold.sv -----
// hold counter, press/release tracking and mode state
`default_nettype none

module bhms_hold import bhms_pkg::*; #(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_step,
    input  logic         i_cmd,
    input  logic         i_pressed,
    input  t_cfg         i_cfg,
    output t_mode        o_mode,
    output logic         o_changed,
    output t_hold_status o_status
);

    localparam int CMP_W = (HOLD_COUNT_BITS > THR_W) ? HOLD_COUNT_BITS : THR_W;

    logic [HOLD_COUNT_BITS-1:0] r_count, n_count;
    logic                       r_active, n_active;
    logic                       r_rel, n_rel;
    logic                       r_long, n_long;
    t_mode                      r_mode, n_mode;

    logic [HOLD_COUNT_BITS-1:0] cnt_inc;
    logic [HOLD_COUNT_BITS-1:0] cnt_eval;
    logic                       long_hit;
    logic                       short_hit;
    logic                       fire;

    always_comb begin
        cnt_inc = (r_active && (r_count != {HOLD_COUNT_BITS{1'b1}}))
                ? r_count + {{(HOLD_COUNT_BITS-1){1'b0}}, 1'b1} : r_count;
        cnt_eval  = (i_pressed && !r_active) ? '0 : cnt_inc;
        long_hit  = CMP_W'(cnt_eval) >= CMP_W'(i_cfg.long_hold);
        short_hit = CMP_W'(cnt_eval) >= CMP_W'(i_cfg.short_hold);
    end

    always_comb begin
        n_count  = r_count;
        n_active = r_active;
        n_rel    = r_rel;
        n_long   = r_long;
        n_mode   = r_mode;
        fire     = 1'b0;
        if (t_cmd'(i_cmd) == CMD_LINK) begin
            n_mode = MODE_LINKED;
        end else begin
            n_count = cnt_eval;
            if (i_pressed) begin
                if (!r_active) begin
                    n_active = 1'b1;
                    n_rel    = 1'b0;
                end
                if (long_hit && !r_long) begin
                    fire   = 1'b1;
                    n_long = 1'b1;
                end
            end else begin
                if (r_active && !r_rel) begin
                    if (r_long) begin
                        n_long = 1'b0;
                    end else begin
                        fire = 1'b1;
                    end
                    n_rel = 1'b1;
                end
                n_active = 1'b0;
            end
            if (fire) begin
                priority if (long_hit) begin
                    n_mode = MODE_BLACK;
                end else if (short_hit) begin
                    n_mode = next_mode(r_mode);
                end else begin
                    n_mode = r_mode;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= 1'b0;
            r_rel    <= 1'b0;
            r_long   <= 1'b0;
            r_mode   <= MODE_IDLE;
        end else if (i_step) begin
            r_count  <= n_count;
            r_active <= n_active;
            r_rel    <= n_rel;
            r_long   <= n_long;
            r_mode   <= n_mode;
        end
    end

    assign o_mode                   = n_mode;
    assign o_changed                = n_mode != r_mode;
    assign o_status.active          = r_active;
    assign o_status.release_handled = r_rel;
    assign o_status.long_fired      = r_long;

endmodule

`default_nettype wire

// ----- sv/button_hold_mode_selector_core.sv -----
// top level: input register, hold/mode update, result register and apb config
// path: an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle while the result side is ready; a stalled result
// holds the input register and so the input ready
// reset: synchronous active low; clears hold state, mode to idle, thresholds
// to 50 and 1000 ticks, and empties both registers
`default_nettype none

module button_hold_mode_selector_core import bhms_pkg::*; #(
    parameter int HOLD_COUNT_BITS = HOLD_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bhms_item_if.sink             i_item,
    bhms_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic         r_in_valid;
    logic         r_in_cmd;
    logic         r_in_pressed;
    logic         r_out_valid;
    t_mode        r_out_mode;
    logic         r_out_changed;

    logic         advance;
    logic         step;
    t_cfg         cfg;
    t_mode        core_mode;
    logic         core_changed;
    t_hold_status status;

    assign advance      = !r_out_valid || o_result.ready;
    assign step         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    bhms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bhms_hold #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_hold (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_cmd     (r_in_cmd),
        .i_pressed (r_in_pressed),
        .i_cfg     (cfg),
        .o_mode    (core_mode),
        .o_changed (core_changed),
        .o_status  (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_cmd     <= i_item.cmd;
            r_in_pressed <= i_item.button_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_mode    <= core_mode;
            r_out_changed <= core_changed;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.mode         = r_out_mode;
    assign o_result.mode_changed = r_out_changed;

    a_long_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.long_fired |-> status.active)
        else $error("long event flag set without an active press");

    a_active_not_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.active |-> !status.release_handled)
        else $error("active press already marked as released");

    a_step_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("processed item did not reach the result register");

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_hold_mode_selector_core.sv -----
// self-checking testbench for the button hold mode selector core
`default_nettype none

module tb_button_hold_mode_selector_core;
    import bhms_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_PRESS_LEN  = 120;
    localparam int PHASE_ITEMS    = 210;

    typedef struct {
        t_cmd cmd;
        logic btn;
    } t_button_item;

    typedef struct {
        t_mode mode;
        logic  changed;
    } t_mode_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    bhms_item_if   item_ch();
    bhms_result_if res_ch();

    button_hold_mode_selector_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 i_clk = ~i_clk;

    t_button_item pend_q[$];
    t_mode_result mode_q[$];

    int src_idle_pct = 18;
    int snk_idle_pct = 66;
    logic hold_off = 1'b0;

    int item_cnt = 0;
    int accepted_cnt = 0;
    int result_cnt = 0;
    int change_cnt = 0;
    int setting_cnt = 0;
    int err_cnt = 0;
    int stall_cycles = 0;

    // predictor state
    logic [THR_W-1:0] thr_short = SHORT_HOLD_RESET;
    logic [THR_W-1:0] thr_long  = LONG_HOLD_RESET;
    logic [15:0]      hold_cnt = '0;
    logic             hold_active = 1'b0;
    logic             rel_done = 1'b0;
    logic             long_done = 1'b0;
    t_mode            cur_mode = MODE_IDLE;

    initial begin
        item_ch.valid = 1'b0;
        item_ch.cmd = 1'b0;
        item_ch.button_pressed = 1'b0;
        res_ch.ready = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        if (err_cnt < 40)
            $display("mismatch on result %0d: %s got %0d expected %0d",
                     result_cnt, what, got, want);
        err_cnt++;
    endtask

    task automatic apply_hold_event();
        if (hold_cnt >= thr_long) begin
            cur_mode = MODE_BLACK;
        end else if (hold_cnt >= thr_short) begin
            if (cur_mode <= MODE_BLACK || cur_mode >= MODE_WHITE)
                cur_mode = MODE_IDENTIFY;
            else
                cur_mode = t_mode'(cur_mode + 3'd1);
        end
    endtask

    task automatic predict_mode(input logic cmd, input logic btn);
        t_mode prev;
        t_mode_result r;
        prev = cur_mode;
        if (cmd == CMD_LINK) begin
            cur_mode = MODE_LINKED;
        end else begin
            if (hold_active && hold_cnt != 16'hFFFF)
                hold_cnt = hold_cnt + 16'd1;
            if (btn) begin
                if (!hold_active) begin
                    hold_cnt = '0;
                    hold_active = 1'b1;
                    rel_done = 1'b0;
                end
                if (hold_cnt >= thr_long && !long_done) begin
                    apply_hold_event();
                    long_done = 1'b1;
                end
            end else begin
                if (hold_active && !rel_done) begin
                    if (long_done)
                        long_done = 1'b0;
                    else
                        apply_hold_event();
                    rel_done = 1'b1;
                end
                hold_active = 1'b0;
            end
        end
        r.mode = cur_mode;
        r.changed = (cur_mode != prev);
        mode_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_button_item it;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                predict_mode(item_ch.cmd, item_ch.button_pressed);
                accepted_cnt++;
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (pend_q.size() != 0 && !hold_off &&
                    $urandom_range(0, 99) >= src_idle_pct) begin
                    it = pend_q.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.cmd <= it.cmd;
                    item_ch.button_pressed <= it.btn;
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_mode_result r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            if (res_ch.valid && res_ch.ready) begin
                if (mode_q.size() == 0) begin
                    report("unexpected transfer, mode", res_ch.mode, -1);
                end else begin
                    r = mode_q.pop_front();
                    if (res_ch.mode !== r.mode)
                        report("mode", res_ch.mode, r.mode);
                    if (res_ch.mode_changed !== r.changed)
                        report("mode_changed", res_ch.mode_changed, r.changed);
                    if (r.changed)
                        change_cnt++;
                end
                result_cnt++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
            || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", mode_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic add_item(input t_cmd cmd, input logic btn);
        t_button_item it;
        it.cmd = cmd;
        it.btn = btn;
        pend_q.push_back(it);
        item_cnt++;
    endtask

    task automatic wait_idle();
        while (pend_q.size() != 0 || accepted_cnt != item_cnt || mode_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [THR_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(int'(idx) * 4);
        pwdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_SHORT_HOLD)
            thr_short = val;
        else
            thr_long = val;
    endtask

    task automatic set_thresholds(input int s, input int l);
        wait_idle();
        apb_write(REG_SHORT_HOLD, THR_W'(s));
        apb_write(REG_LONG_HOLD, THR_W'(l));
        setting_cnt++;
    endtask

    function automatic int pick_press_len();
        int sel, len;
        sel = $urandom_range(0, 3);
        case (sel)
            0: len = int'(thr_short) + $urandom_range(0, 2) - 1;
            1: len = int'(thr_long) + $urandom_range(0, 2) - 1;
            2: len = $urandom_range(1, 40);
            default: len = $urandom_range(1, 3);
        endcase
        if (len < 1) len = 1;
        if (len > MAX_PRESS_LEN) len = $urandom_range(MAX_PRESS_LEN - 20, MAX_PRESS_LEN);
        return len;
    endfunction

    task automatic add_random_burst();
        int kind, len, gap;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            gap = $urandom_range(0, 3);
            repeat (gap) add_item(CMD_TICK, 1'b0);
            len = pick_press_len();
            add_item(CMD_TICK, 1'b1);
            for (int i = 1; i < len; i++) begin
                if ($urandom_range(0, 99) < 4)
                    add_item(CMD_LINK, 1'($urandom_range(0, 1)));
                else
                    add_item(CMD_TICK, 1'b1);
            end
            add_item(CMD_TICK, 1'b0);
        end else if (kind < 90) begin
            add_item(CMD_LINK, 1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(1, 6))
                add_item(t_cmd'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input int s, input int l, input int src_pct,
                             input int snk_pct, input logic mid_pause);
        int start;
        set_thresholds(s, l);
        @(posedge i_clk);
        src_idle_pct <= src_pct;
        snk_idle_pct <= snk_pct;
        start = item_cnt;
        while (item_cnt - start < PHASE_ITEMS)
            add_random_burst();
        if (mid_pause) begin
            while (pend_q.size() > PHASE_ITEMS / 2) @(posedge i_clk);
            hold_off <= 1'b1;
            @(posedge i_clk);
            while (accepted_cnt + pend_q.size() != item_cnt || mode_q.size() != 0)
                @(posedge i_clk);
            hold_off <= 1'b0;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: link, short and long releases, long event while held
        set_thresholds(2, 4);
        add_item(CMD_LINK, 1'b0);
        add_item(CMD_LINK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_LINK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);

        // zero thresholds, then a long threshold at the counter maximum
        set_thresholds(0, 0);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        set_thresholds(0, 65535);
        add_item(CMD_TICK, 1'b1);
        add_item(CMD_TICK, 1'b0);
        add_item(CMD_TICK, 1'b0);

        run_phase(3, 10, 18, 66, 1'b0);
        run_phase(50, 1000, 18, 66, 1'b1);
        run_phase(0, 5, 18, 66, 1'b0);
        run_phase(7, 7, 66, 18, 1'b0);
        run_phase(65535, 65535, 66, 18, 1'b0);
        run_phase(10, 3, 66, 18, 1'b1);
        run_phase(1, 65535, 0, 0, 1'b0);
        run_phase($urandom_range(0, 15), $urandom_range(0, 30), 0, 0, 1'b0);

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("run covered %0d items and %0d results over %0d threshold settings",
                 accepted_cnt, result_cnt, setting_cnt);
        $display("%0d results reported a mode change, %0d mismatches", change_cnt, err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/bhms_pkg.sv
sv/bhms_if.sv
sv/bhms_cfg.sv
sv/bhms_hold.sv
sv/button_hold_mode_selector_core.sv
tb/sv/tb_button_hold_mode_selector_core.sv
